/* rtl/core/nllfp_pkg.sv */
package nllfp_pkg;

    localparam int FRACTION_DIGITS_DEF = 4;
    localparam int WHOLE_DIGITS_DEF    = 6;

    localparam int WHOLE_W = 20;
    localparam int FRAC_W  = 14;
    localparam int CHAR_W  = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2e;
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2c;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LAT_WHOLE,
        PH_LAT_FRAC,
        PH_LAT_DIR,
        PH_LAT_SEP,
        PH_LON_WHOLE,
        PH_LON_FRAC,
        PH_LON_DIR
    } phase_t;

    // one byte handed from the input stage to the parser
    typedef struct packed {
        logic              fire;
        logic              start_req;
        logic [CHAR_W-1:0] data_byte;
    } step_t;

    typedef struct packed {
        logic               format_error;
        logic [CHAR_W-1:0]  lon_hemisphere;
        logic [FRAC_W-1:0]  lon_fraction;
        logic [WHOLE_W-1:0] lon_whole;
        logic [CHAR_W-1:0]  lat_hemisphere;
        logic [FRAC_W-1:0]  lat_fraction;
        logic [WHOLE_W-1:0] lat_whole;
    } result_t;

    // elaboration-time power of ten
    function automatic logic [63:0] pow10(input int n);
        logic [63:0] v;
        v = 64'd1;
        for (int i = 0; i < n; i++) begin
            v = v * 64'd10;
        end
        return v;
    endfunction

endpackage

/* rtl/core/nllfp_core.sv */
module nllfp_core #(
    parameter int FRACTION_DIGITS = nllfp_pkg::FRACTION_DIGITS_DEF,
    parameter int WHOLE_DIGITS    = nllfp_pkg::WHOLE_DIGITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  nllfp_pkg::step_t    step,
    output logic                emit,
    output nllfp_pkg::result_t  result
);

    localparam int WW = $clog2(nllfp_pkg::pow10(WHOLE_DIGITS));
    localparam int FW = $clog2(nllfp_pkg::pow10(FRACTION_DIGITS));
    localparam int CW = $clog2(FRACTION_DIGITS + 1);
    localparam logic [WW-1:0] WHOLE_LIMIT = WW'(nllfp_pkg::pow10(WHOLE_DIGITS) - 64'd1);

    nllfp_pkg::phase_t phase_reg, phase_next;
    logic [WW-1:0] lat_whole_reg, lat_whole_next;
    logic [WW-1:0] lon_whole_reg, lon_whole_next;
    logic [FW-1:0] lat_frac_reg, lat_frac_next;
    logic [FW-1:0] lon_frac_reg, lon_frac_next;
    logic [nllfp_pkg::CHAR_W-1:0] lat_dir_reg, lat_dir_next;
    logic [CW-1:0] count_reg, count_next;
    logic          error_reg, error_next;

    // values seen by this byte after an optional restart
    nllfp_pkg::phase_t ph;
    logic [WW-1:0] lat_whole_cur, lon_whole_cur, whole_src, whole_new;
    logic [FW-1:0] lat_frac_cur, lon_frac_cur, frac_src, frac_new, frac_weight;
    logic [nllfp_pkg::CHAR_W-1:0] lat_dir_cur;
    logic [CW-1:0] count_cur;
    logic          error_cur;
    logic          is_digit;
    logic [3:0]    digit;
    logic [WW+3:0] whole_ext, whole_sum;
    logic          whole_sat;
    logic          frac_take;

    assign ph            = step.start_req ? nllfp_pkg::PH_LAT_WHOLE : phase_reg;
    assign lat_whole_cur = step.start_req ? '0 : lat_whole_reg;
    assign lon_whole_cur = step.start_req ? '0 : lon_whole_reg;
    assign lat_frac_cur  = step.start_req ? '0 : lat_frac_reg;
    assign lon_frac_cur  = step.start_req ? '0 : lon_frac_reg;
    assign lat_dir_cur   = step.start_req ? '0 : lat_dir_reg;
    assign count_cur     = step.start_req ? '0 : count_reg;
    assign error_cur     = step.start_req ? 1'b0 : error_reg;

    assign is_digit = (step.data_byte >= nllfp_pkg::CHAR_ZERO)
                   && (step.data_byte <= nllfp_pkg::CHAR_NINE);
    assign digit    = step.data_byte[3:0];

    // shared whole-part unit: acc * 10 + digit, saturated
    assign whole_src = (ph == nllfp_pkg::PH_LON_WHOLE) ? lon_whole_cur : lat_whole_cur;
    assign whole_ext = (WW+4)'(whole_src);
    assign whole_sum = (whole_ext << 3) + (whole_ext << 1) + (WW+4)'(digit);
    assign whole_sat = whole_sum > (WW+4)'(WHOLE_LIMIT);
    assign whole_new = whole_sat ? WHOLE_LIMIT : whole_sum[WW-1:0];

    // shared fraction unit: add digit at its decimal place
    always_comb begin
        frac_weight = '0;
        for (int i = 0; i < FRACTION_DIGITS; i++) begin
            if (count_cur == CW'(i)) begin
                frac_weight = FW'(nllfp_pkg::pow10(FRACTION_DIGITS - 1 - i));
            end
        end
    end

    assign frac_take = count_cur < CW'(FRACTION_DIGITS);
    assign frac_src  = (ph == nllfp_pkg::PH_LON_FRAC) ? lon_frac_cur : lat_frac_cur;
    assign frac_new  = frac_src + FW'(FW'(digit) * frac_weight);

    assign emit = (ph == nllfp_pkg::PH_LON_DIR);

    always_comb begin
        phase_next     = ph;
        lat_whole_next = lat_whole_cur;
        lon_whole_next = lon_whole_cur;
        lat_frac_next  = lat_frac_cur;
        lon_frac_next  = lon_frac_cur;
        lat_dir_next   = lat_dir_cur;
        count_next     = count_cur;
        error_next     = error_cur;
        unique case (ph)
            nllfp_pkg::PH_LAT_WHOLE,
            nllfp_pkg::PH_LON_WHOLE: begin
                if (step.data_byte == nllfp_pkg::CHAR_POINT) begin
                    count_next = '0;
                    phase_next = (ph == nllfp_pkg::PH_LAT_WHOLE) ? nllfp_pkg::PH_LAT_FRAC
                                                                 : nllfp_pkg::PH_LON_FRAC;
                end else if (!is_digit) begin
                    error_next = 1'b1;
                end else begin
                    if (whole_sat) begin
                        error_next = 1'b1;
                    end
                    if (ph == nllfp_pkg::PH_LAT_WHOLE) begin
                        lat_whole_next = whole_new;
                    end else begin
                        lon_whole_next = whole_new;
                    end
                end
            end
            nllfp_pkg::PH_LAT_FRAC,
            nllfp_pkg::PH_LON_FRAC: begin
                if (step.data_byte == nllfp_pkg::CHAR_COMMA) begin
                    phase_next = (ph == nllfp_pkg::PH_LAT_FRAC) ? nllfp_pkg::PH_LAT_DIR
                                                                : nllfp_pkg::PH_LON_DIR;
                end else if (!is_digit) begin
                    error_next = 1'b1;
                end else if (frac_take) begin
                    count_next = count_cur + CW'(1);
                    if (ph == nllfp_pkg::PH_LAT_FRAC) begin
                        lat_frac_next = frac_new;
                    end else begin
                        lon_frac_next = frac_new;
                    end
                end
            end
            nllfp_pkg::PH_LAT_DIR: begin
                lat_dir_next = step.data_byte;
                phase_next   = nllfp_pkg::PH_LAT_SEP;
            end
            nllfp_pkg::PH_LAT_SEP: begin
                phase_next = nllfp_pkg::PH_LON_WHOLE;
            end
            nllfp_pkg::PH_LON_DIR: begin
                phase_next = nllfp_pkg::PH_IDLE;
            end
            default: begin
                phase_next = nllfp_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb begin
        result.lat_whole      = nllfp_pkg::WHOLE_W'(lat_whole_cur);
        result.lat_fraction   = nllfp_pkg::FRAC_W'(lat_frac_cur);
        result.lat_hemisphere = lat_dir_cur;
        result.lon_whole      = nllfp_pkg::WHOLE_W'(lon_whole_cur);
        result.lon_fraction   = nllfp_pkg::FRAC_W'(lon_frac_cur);
        result.lon_hemisphere = step.data_byte;
        result.format_error   = error_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= nllfp_pkg::PH_IDLE;
            lat_whole_reg <= '0;
            lon_whole_reg <= '0;
            lat_frac_reg  <= '0;
            lon_frac_reg  <= '0;
            lat_dir_reg   <= '0;
            count_reg     <= '0;
            error_reg     <= 1'b0;
        end else if (step.fire) begin
            phase_reg     <= phase_next;
            lat_whole_reg <= lat_whole_next;
            lon_whole_reg <= lon_whole_next;
            lat_frac_reg  <= lat_frac_next;
            lon_frac_reg  <= lon_frac_next;
            lat_dir_reg   <= lat_dir_next;
            count_reg     <= count_next;
            error_reg     <= error_next;
        end
    end

endmodule

/* rtl/core/nmea_lat_long_field_parser.sv */
// parses the coordinate text "ddmm.mmmm,N,dddmm.mmmm,W" one ascii character per beat
// slave channel: s_tdata carries the character, s_tuser high marks the first
// character of the latitude field and restarts the parse from any point
// master channel: one beat per coordinate pair, sent on the longitude direction
// character; m_tdata holds latitude and longitude whole parts, fractions in
// units of 10^-FRACTION_DIGITS and both direction characters, m_tuser flags a
// non-digit character in a number field or a whole part clipped at 10^WHOLE_DIGITS-1
// throughput: one character per cycle except under the stall below; the
// per-character update is a multiply-by-ten add or a weighted fraction add
// between the input register and the parser state; a direction character
// passes the input register, then its result beat is held in the result register
// reset: the parser goes idle and ignores characters until a start beat;
// both channel registers are emptied
// stall: a held result beat keeps ready low only when the next character would
// produce another result; all other characters keep flowing at full rate
module nmea_lat_long_field_parser #(
    parameter int FRACTION_DIGITS = nllfp_pkg::FRACTION_DIGITS_DEF,
    parameter int WHOLE_DIGITS    = nllfp_pkg::WHOLE_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [19:0] lat_whole, [33:20] lat_fraction,
                                   // [41:34] lat_hemisphere, [61:42] lon_whole,
                                   // [75:62] lon_fraction, [83:76] lon_hemisphere,
                                   // [87:84] zero
    output logic        m_tuser    // [0] format_error
);

    logic                          in_valid_reg;
    logic [nllfp_pkg::CHAR_W-1:0]  in_byte_reg;
    logic                          in_start_reg;
    logic                          out_valid_reg, out_valid_next;
    nllfp_pkg::result_t            out_reg;

    nllfp_pkg::step_t   step;
    nllfp_pkg::result_t result;
    logic               emit;
    logic               fire;
    logic               out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && (!emit || out_free);
    assign s_tready = !in_valid_reg || fire;

    assign step.fire      = fire;
    assign step.start_req = in_start_reg;
    assign step.data_byte = in_byte_reg;

    nllfp_core #(
        .FRACTION_DIGITS (FRACTION_DIGITS),
        .WHOLE_DIGITS    (WHOLE_DIGITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .emit    (emit),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (fire && emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.format_error;
    assign m_tdata  = {4'b0000,
                       out_reg.lon_hemisphere,
                       out_reg.lon_fraction,
                       out_reg.lon_whole,
                       out_reg.lat_hemisphere,
                       out_reg.lat_fraction,
                       out_reg.lat_whole};

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

    import nllfp_pkg::*;

    typedef struct packed {
        logic        start_req;
        logic [7:0]  data_byte;
    } char_beat_t;

    typedef enum {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_t;

    localparam int HOLD_CYCLES = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tuser;   // [0] start_req
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;   // [19:0] lat_whole, [33:20] lat_fraction,
                            // [41:34] lat_hemisphere, [61:42] lon_whole,
                            // [75:62] lon_fraction, [83:76] lon_hemisphere,
                            // [87:84] zero
    logic        m_tuser;   // [0] format_error

    nmea_lat_long_field_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    char_beat_t  char_q[$];
    result_t     coord_q[$];
    logic [7:0]  rec_q[$];

    // parser state mirrored by the testbench
    phase_t      pm_phase;
    logic [19:0] pm_lat_whole;
    logic [13:0] pm_lat_frac;
    logic [7:0]  pm_lat_dir;
    logic [19:0] pm_lon_whole;
    logic [13:0] pm_lon_frac;
    int          pm_frac_cnt;
    logic        pm_err;

    int n_gen, n_chars, n_pairs, n_restarts, n_flagged, n_in_stalls, n_errors;
    bit in_beat;
    bit hold_off;
    int burst_left, gap_left;
    char_beat_t drv_beat;
    rx_mode_t rx_mode;
    int rx_left;
    bit rx_ok;
    result_t got, want;
    bit bad;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- prediction

    task automatic add_whole(inout logic [19:0] acc, input logic [7:0] b);
        int v;
        int lim;
        lim = 1;
        for (int i = 0; i < WHOLE_DIGITS_DEF; i++) lim = lim * 10;
        lim = lim - 1;
        if (b < CHAR_ZERO || b > CHAR_NINE) begin
            pm_err = 1'b1;
        end else begin
            v = acc * 10 + (b - CHAR_ZERO);
            if (v > lim) begin
                v = lim;
                pm_err = 1'b1;
            end
            acc = v[19:0];
        end
    endtask

    task automatic add_frac(inout logic [13:0] acc, input logic [7:0] b);
        int w;
        if (b < CHAR_ZERO || b > CHAR_NINE) begin
            pm_err = 1'b1;
        end else if (pm_frac_cnt < FRACTION_DIGITS_DEF) begin
            // digits past the fixed point width are dropped
            w = 1;
            for (int i = 0; i < FRACTION_DIGITS_DEF - 1 - pm_frac_cnt; i++) w = w * 10;
            acc = acc + (b - CHAR_ZERO) * w;
            pm_frac_cnt++;
        end
    endtask

    task automatic parse_char(input logic [7:0] b, input logic st);
        result_t r;
        if (st) begin
            pm_lat_whole = '0;
            pm_lat_frac  = '0;
            pm_lat_dir   = '0;
            pm_lon_whole = '0;
            pm_lon_frac  = '0;
            pm_frac_cnt  = 0;
            pm_err       = 1'b0;
            pm_phase     = PH_LAT_WHOLE;
            n_restarts++;
        end
        case (pm_phase)
            PH_LAT_WHOLE: begin
                if (b == CHAR_POINT) begin
                    pm_frac_cnt = 0;
                    pm_phase = PH_LAT_FRAC;
                end else begin
                    add_whole(pm_lat_whole, b);
                end
            end
            PH_LAT_FRAC: begin
                if (b == CHAR_COMMA) pm_phase = PH_LAT_DIR;
                else add_frac(pm_lat_frac, b);
            end
            PH_LAT_DIR: begin
                pm_lat_dir = b;
                pm_phase = PH_LAT_SEP;
            end
            // separator byte is skipped whatever it holds
            PH_LAT_SEP: pm_phase = PH_LON_WHOLE;
            PH_LON_WHOLE: begin
                if (b == CHAR_POINT) begin
                    pm_frac_cnt = 0;
                    pm_phase = PH_LON_FRAC;
                end else begin
                    add_whole(pm_lon_whole, b);
                end
            end
            PH_LON_FRAC: begin
                if (b == CHAR_COMMA) pm_phase = PH_LON_DIR;
                else add_frac(pm_lon_frac, b);
            end
            PH_LON_DIR: begin
                r.lat_whole      = pm_lat_whole;
                r.lat_fraction   = pm_lat_frac;
                r.lat_hemisphere = pm_lat_dir;
                r.lon_whole      = pm_lon_whole;
                r.lon_fraction   = pm_lon_frac;
                r.lon_hemisphere = b;
                r.format_error   = pm_err;
                coord_q.push_back(r);
                pm_phase = PH_IDLE;
            end
            default: pm_phase = PH_IDLE;
        endcase
    endtask

    // ---------------------------------------------------------------- stimulus

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) rec_q.push_back(s[i]);
    endtask

    // moves the staged bytes to the driver, start flag on the first one if with_start is set
    task automatic flush_rec(input bit with_start);
        char_beat_t cb;
        for (int i = 0; i < rec_q.size(); i++) begin
            cb.start_req = with_start && (i == 0);
            cb.data_byte = rec_q[i];
            char_q.push_back(cb);
        end
        if (with_start) n_gen += rec_q.size();
        rec_q.delete();
    endtask

    task automatic add_digits(input int n, input bit nines, input logic [7:0] term);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = nines ? CHAR_NINE : CHAR_ZERO + $urandom_range(0, 9);
            if ($urandom_range(0, 39) == 0) begin
                b = $urandom_range(0, 255);
                if (b == term) b = b ^ 8'h80;
            end
            rec_q.push_back(b);
        end
    endtask

    task automatic add_coord(input int usual_whole);
        int nw;
        int nf;
        nw = ($urandom_range(0, 7) < 5) ? usual_whole : $urandom_range(0, 9);
        nf = ($urandom_range(0, 7) < 5) ? FRACTION_DIGITS_DEF : $urandom_range(0, 7);
        add_digits(nw, $urandom_range(0, 15) == 0, CHAR_POINT);
        rec_q.push_back(CHAR_POINT);
        add_digits(nf, 1'b0, CHAR_COMMA);
        rec_q.push_back(CHAR_COMMA);
    endtask

    task automatic gen_record(input bit complete);
        int cut;
        int n;
        add_coord(4);
        if ($urandom_range(0, 5) == 0) rec_q.push_back($urandom_range(0, 255));
        else rec_q.push_back($urandom_range(0, 1) ? "N" : "S");
        if ($urandom_range(0, 5) == 0) rec_q.push_back($urandom_range(0, 255));
        else rec_q.push_back(CHAR_COMMA);
        add_coord(5);
        if ($urandom_range(0, 5) == 0) rec_q.push_back($urandom_range(0, 255));
        else rec_q.push_back($urandom_range(0, 1) ? "E" : "W");
        // broken sentence: cut short, the next start beat restarts mid-parse
        if (!complete && $urandom_range(0, 11) == 0) begin
            cut = $urandom_range(1, rec_q.size() - 1);
            while (rec_q.size() > cut) void'(rec_q.pop_back());
        end
        flush_rec(1'b1);
        if (!complete && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) rec_q.push_back($urandom_range(0, 255));
            flush_rec(1'b0);
        end
    endtask

    // ---------------------------------------------------------------- driver

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_beat) begin
            // beat still waiting for ready
        end else if (gap_left > 0) begin
            s_tvalid <= 1'b0;
            gap_left--;
        end else if (char_q.size() > 0) begin
            drv_beat = char_q.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= drv_beat.data_byte;
            s_tuser  <= drv_beat.start_req;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 48);
                gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            end else begin
                burst_left--;
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver ready pattern, switches style when its random run counter runs out
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:   rx_ok = 1'b1;
            RX_COIN:   rx_ok = $urandom_range(0, 1);
            RX_SPARSE: rx_ok = ($urandom_range(0, 3) == 0);
            default:   rx_ok = !m_tready;
        endcase
        m_tready <= !hold_off && rx_ok;
    end

    // long receiver hold-off so the parser backs up into its input
    initial begin
        hold_off = 1'b0;
        wait (n_pairs >= 8);
        @(posedge aclk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off = 1'b0;
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge aclk) begin
        in_beat = aresetn && s_tvalid && s_tready;
        if (in_beat) begin
            parse_char(s_tdata, s_tuser);
            n_chars++;
        end
        if (aresetn && s_tvalid && !s_tready) n_in_stalls++;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'({m_tuser, m_tdata[83:0]});
            n_pairs++;
            if (got.format_error) n_flagged++;
            if (coord_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result beat: lat %0d.%0d lon %0d.%0d err %0b",
                             got.lat_whole, got.lat_fraction, got.lon_whole,
                             got.lon_fraction, got.format_error);
            end else begin
                want = coord_q.pop_front();
                bad = (got.lat_whole != want.lat_whole)
                   || (got.lat_fraction != want.lat_fraction)
                   || (got.lat_hemisphere != want.lat_hemisphere)
                   || (got.lon_whole != want.lon_whole)
                   || (got.lon_fraction != want.lon_fraction)
                   || (got.lon_hemisphere != want.lon_hemisphere)
                   || (got.format_error != want.format_error)
                   || (m_tdata[87:84] !== 4'h0);
                if (bad) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("mismatch at %0t: expected lat %0d.%0d %h lon %0d.%0d %h err %0b",
                                 $realtime, want.lat_whole, want.lat_fraction,
                                 want.lat_hemisphere, want.lon_whole, want.lon_fraction,
                                 want.lon_hemisphere, want.format_error);
                        $display("    got lat %0d.%0d %h lon %0d.%0d %h err %0b pad %h",
                                 got.lat_whole, got.lat_fraction, got.lat_hemisphere,
                                 got.lon_whole, got.lon_fraction, got.lon_hemisphere,
                                 got.format_error, m_tdata[87:84]);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        in_beat    = 1'b0;
        burst_left = 0;
        gap_left   = 0;
        rx_mode    = RX_OPEN;
        rx_left    = 0;
        pm_phase   = PH_IDLE;
        pm_lat_whole = '0;
        pm_lat_frac  = '0;
        pm_lat_dir   = '0;
        pm_lon_whole = '0;
        pm_lon_frac  = '0;
        pm_frac_cnt  = 0;
        pm_err       = 1'b0;
        n_gen = 0; n_chars = 0; n_pairs = 0; n_restarts = 0;
        n_flagged = 0; n_in_stalls = 0; n_errors = 0;

        // stray byte while idle, ignored
        push_text("5");
        flush_rec(1'b0);
        // empty whole parts and empty fractions
        push_text(".,N,.,S");
        flush_rec(1'b1);
        // saturation, truncated fraction, odd separator, bad digits, byte extremes
        push_text("9999999.12345,");
        rec_q.push_back(8'hff);
        push_text("x9a.9,");
        rec_q.push_back(8'h00);
        flush_rec(1'b1);
        // restart in the middle of a fraction
        push_text("3.1");
        flush_rec(1'b1);

        while (n_gen < 1300) gen_record(1'b0);
        gen_record(1'b1);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (char_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (coord_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("run covered %0d characters, %0d start beats, %0d coordinate pairs (%0d with format error)",
                 n_chars, n_restarts, n_pairs, n_flagged);
        $display("input held by backpressure for %0d cycles, one receiver hold-off of %0d cycles",
                 n_in_stalls, HOLD_CYCLES);
        if (n_errors == 0 && coord_q.size() == 0) begin
            $display("[nmea_lat_long_field_parser] OK");
        end else begin
            $display("[nmea_lat_long_field_parser] ERROR");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("[nmea_lat_long_field_parser] ERROR");
        $finish;
    end

endmodule
